// ===== rtl/core/puprl_pkg.sv =====
// Shared types, codes and constants of the per-user problem rate limiter
`timescale 1ns / 1ps
package puprl_pkg;

  // table size and fixed field widths
  localparam int unsigned USER_SLOTS_DEF = 64;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned SLOT_W         = 6;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned CRED_W         = 8;
  localparam int unsigned SESS_W         = 4;
  localparam int unsigned PROB_W         = 32;
  localparam int unsigned PLIM_W         = 16;
  localparam int unsigned SHIFT_W        = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [SESS_W-1:0]  SESSION_LIMIT_RST = 4'd5;
  localparam logic [PLIM_W-1:0]  PROBLEM_LIMIT_RST = 16'd1000;
  localparam logic [SHIFT_W-1:0] REFILL_SHIFT_RST  = 5'd4;
  localparam logic [CRED_W-1:0]  BATCH_SIZE_RST    = 8'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_STORE   = 2'd2,
    KIND_REQUEST = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_THROTTLED     = 3'd1,
    ST_PROBLEM_LIMIT = 3'd2,
    ST_UNKNOWN       = 3'd3,
    ST_TIME_BACK     = 3'd4,
    ST_SESSION_LIMIT = 3'd5,
    ST_NO_SESSION    = 3'd6,
    ST_SATURATED     = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SESSION_LIMIT = 2'd0,
    CFG_PROBLEM_LIMIT = 2'd1,
    CFG_REFILL_SHIFT  = 2'd2,
    CFG_BATCH_SIZE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_REFILL
  } state_e;

  // one user table entry
  typedef struct packed {
    logic              valid;
    logic [SESS_W-1:0] sessions;
    logic [PROB_W-1:0] problems;
    logic [CRED_W-1:0] credits;
    logic [TIME_W-1:0] last_grant;
  } user_rec_t;

  localparam int unsigned REC_W = $bits(user_rec_t);

  // controller to datapath
  typedef struct packed {
    logic clear_step;    // write one zero entry of the sweep
    logic capture;       // take an input item, start the table read
    logic eval;          // table entry is on the read port
    logic eval_commit;   // finish a simple item, load the result
    logic refill_commit; // finish a refilled request, load the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;    // sweep is at its last entry
    logic need_refill;   // request passed its checks, credits to refill
  } dp_sts_t;

endpackage

// ===== rtl/core/puprl_if.sv =====
// Handshake channel interfaces: request items, result items, register writes
`timescale 1ns / 1ps
interface puprl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  user_slot;
  logic [31:0] now_seconds;

  modport source (output valid, kind, user_slot, now_seconds, input ready);
  modport sink (input valid, kind, user_slot, now_seconds, output ready);
endinterface

interface puprl_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] credits_before;

  modport source (output valid, status, credits_before, input ready);
  modport sink (input valid, status, credits_before, output ready);
endinterface

interface puprl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/puprl_ram.sv =====
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module puprl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/puprl_dp.sv =====
// Datapath: config registers, item registers, user table and update logic
`timescale 1ns / 1ps
module puprl_dp import puprl_pkg::*; #(
  parameter int unsigned USER_SLOTS = USER_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SLOT_W-1:0]     user_slot_i,
  input  logic [TIME_W-1:0]     now_seconds_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [CRED_W-1:0]     credits_before_o
);

  localparam int unsigned AW = $clog2(USER_SLOTS);

  // configuration registers
  logic [SESS_W-1:0]  session_limit_q;
  logic [PLIM_W-1:0]  problem_limit_q;
  logic [SHIFT_W-1:0] refill_shift_q;
  logic [CRED_W-1:0]  batch_size_q;

  // item registers
  kind_e             kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] now_q;

  logic [AW-1:0]     clr_cnt_q;
  logic [CRED_W:0]   incr_q, incr_d;
  status_e           status_q, status_d;
  logic [CRED_W-1:0] credits_q, credits_d;

  logic [TIME_W-1:0] slot_ext_rd, slot_ext_q;
  logic [AW-1:0]     raddr, waddr;
  logic              in_range;
  logic [REC_W-1:0]  rd_data, wr_data;
  logic              ram_we;
  user_rec_t         rec, eval_rec, refill_rec;
  logic              eval_we;
  status_e           eval_status, refill_status;
  logic [CRED_W-1:0] eval_before, refill_before;
  logic              need_refill;
  logic [TIME_W-1:0] delta, shifted;
  logic [CRED_W+1:0] sum;
  logic [CRED_W-1:0] refilled;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_limit_q <= SESSION_LIMIT_RST;
      problem_limit_q <= PROBLEM_LIMIT_RST;
      refill_shift_q  <= REFILL_SHIFT_RST;
      batch_size_q    <= BATCH_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SESSION_LIMIT: session_limit_q <= cfg_data_i[SESS_W-1:0];
        CFG_PROBLEM_LIMIT: problem_limit_q <= cfg_data_i[PLIM_W-1:0];
        CFG_REFILL_SHIFT:  refill_shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_BATCH_SIZE:    batch_size_q    <= cfg_data_i[CRED_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == AW'(USER_SLOTS - 1));

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_e'(kind_i);
      slot_q <= user_slot_i;
      now_q  <= now_seconds_i;
    end
  end

  // table addressing
  assign slot_ext_rd = TIME_W'(user_slot_i);
  assign slot_ext_q  = TIME_W'(slot_q);
  assign raddr       = slot_ext_rd[AW-1:0];
  assign in_range    = (slot_ext_q < TIME_W'(USER_SLOTS));
  assign rec         = user_rec_t'(rd_data);

  // first look at the entry: session and problem items finish here, as do requests that need no refill
  always_comb begin
    eval_rec    = rec;
    eval_we     = 1'b0;
    eval_status = ST_OK;
    eval_before = '0;
    need_refill = 1'b0;
    if (!in_range) begin
      eval_status = ST_UNKNOWN;
    end else begin
      case (kind_q)
        KIND_OPEN: begin
          if (!rec.valid) begin
            eval_rec          = '0;
            eval_rec.valid    = 1'b1;
            eval_rec.sessions = SESS_W'(1);
            eval_we           = 1'b1;
          end else if (rec.sessions >= session_limit_q) begin
            eval_status = ST_SESSION_LIMIT;
          end else if (rec.sessions == '1) begin
            eval_status = ST_SATURATED;
          end else begin
            eval_rec.sessions = rec.sessions + 1'b1;
            eval_we           = 1'b1;
          end
        end
        KIND_CLOSE: begin
          if (!rec.valid) begin
            eval_status = ST_UNKNOWN;
          end else if (rec.sessions == '0) begin
            eval_status = ST_NO_SESSION;
          end else begin
            eval_rec.sessions = rec.sessions - 1'b1;
            eval_we           = 1'b1;
          end
        end
        KIND_STORE: begin
          if (!rec.valid) begin
            // fresh record with the first problem counted
            eval_rec          = '0;
            eval_rec.valid    = 1'b1;
            eval_rec.problems = PROB_W'(1);
            eval_we           = 1'b1;
          end else if (rec.problems == '1) begin
            eval_status = ST_SATURATED;
          end else begin
            eval_rec.problems = rec.problems + 1'b1;
            eval_we           = 1'b1;
          end
        end
        default: begin
          if (slot_q == '0) begin
            // root always passes
            eval_before = CRED_W'(1);
          end else if (!rec.valid) begin
            eval_status = ST_UNKNOWN;
          end else if (problem_limit_q != '0 &&
                       rec.problems >= PROB_W'(problem_limit_q)) begin
            eval_status = ST_PROBLEM_LIMIT;
          end else if (now_q < rec.last_grant) begin
            eval_status = ST_TIME_BACK;
          end else begin
            need_refill = 1'b1;
          end
        end
      endcase
    end
  end

  assign sts_o.need_refill = need_refill;

  // elapsed time to credits, held at 256 since no batch exceeds 255
  assign delta   = now_q - rec.last_grant;
  assign shifted = delta >> refill_shift_q;
  assign incr_d  = (shifted > TIME_W'(255)) ? {1'b1, {CRED_W{1'b0}}}
                                            : {1'b0, shifted[CRED_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      incr_q <= incr_d;
    end
  end

  // refill, cap, spend one credit if any is left
  always_comb begin
    sum           = {2'b00, rec.credits} + {1'b0, incr_q};
    refilled      = (sum > {2'b00, batch_size_q}) ? batch_size_q : sum[CRED_W-1:0];
    refill_rec    = rec;
    refill_status = ST_OK;
    refill_before = '0;
    if (refilled == '0) begin
      refill_rec.credits = refilled;
      refill_status      = ST_THROTTLED;
    end else begin
      refill_rec.credits    = refilled - 1'b1;
      refill_rec.last_grant = now_q;
      refill_before         = refilled;
    end
  end

  // table write port
  assign ram_we  = cmd_i.clear_step | (cmd_i.eval_commit & eval_we) | cmd_i.refill_commit;
  assign waddr   = cmd_i.clear_step ? clr_cnt_q : slot_ext_q[AW-1:0];
  always_comb begin
    if (cmd_i.clear_step) begin
      wr_data = '0;
    end else if (cmd_i.refill_commit) begin
      wr_data = refill_rec;
    end else begin
      wr_data = eval_rec;
    end
  end

  puprl_ram #(
    .WIDTH (REC_W),
    .DEPTH (USER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.capture),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // result register
  always_comb begin
    status_d  = status_q;
    credits_d = credits_q;
    if (cmd_i.refill_commit) begin
      status_d  = refill_status;
      credits_d = refill_before;
    end else if (cmd_i.eval_commit) begin
      status_d  = eval_status;
      credits_d = eval_before;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    credits_q <= credits_d;
  end

  assign status_o         = status_q;
  assign credits_before_o = credits_q;

endmodule

// ===== rtl/core/puprl_ctrl.sv =====
// Controller: clearing sweep, item sequencing and result handshake
`timescale 1ns / 1ps
module puprl_ctrl import puprl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // result register can take a new value
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.need_refill) begin
          state_d = S_REFILL;
        end else if (out_free) begin
          cmd_o.eval_commit = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_REFILL: begin
        if (out_free) begin
          cmd_o.refill_commit = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // result valid: set on commit, cleared on transfer
  always_comb begin
    if (cmd_o.eval_commit || cmd_o.refill_commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== rtl/core/per_user_problem_rate_limiter_top.sv =====
// Top level of the per-user problem rate limiter
`timescale 1ns / 1ps
// Usage
// - req_i carries one item per transfer: kind, user_slot, now_seconds.
//   Kinds are session open, session close, problem stored, new-problem request.
// - rsp_o returns exactly one result per item: status and credits_before.
// - cfg_i writes session_limit, problem_limit, refill_shift, batch_size by index;
//   it is always ready and should be written only while no item is in flight.
// - Per-user records sit in a single-port-write RAM of USER_SLOTS entries;
//   every item is one read of its entry and at most one write back.
// - Timing: the table is read at acceptance, then the entry is evaluated, any
//   change written back and the result register loaded; a request that reaches
//   the credit refill first registers the elapsed-time shift, then commits from
//   the refill state. One item is in flight at a time, so no new item is taken
//   before the last one commits, bounded by the table read-modify-write.
// - Reset: the table is swept to zero, one entry a cycle, over all USER_SLOTS
//   entries; req_i.ready stays low during the sweep, config writes are taken.
// - The result register lets the next item be accepted while a result waits;
//   if rsp_o stalls, the following item holds before commit until it drains.
module per_user_problem_rate_limiter_top import puprl_pkg::*; #(
  parameter int unsigned USER_SLOTS = USER_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  puprl_req_if.sink   req_i,
  puprl_rsp_if.source rsp_o,
  puprl_cfg_if.sink   cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  puprl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  puprl_dp #(
    .USER_SLOTS (USER_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (req_i.kind),
    .user_slot_i      (req_i.user_slot),
    .now_seconds_i    (req_i.now_seconds),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .status_o         (rsp_o.status),
    .credits_before_o (rsp_o.credits_before)
  );

endmodule

// ===== rtl/core/puprl_sva.sv =====
// Port-level checker for the rate limiter, bound to the top level
`timescale 1ns / 1ps
module puprl_sva import puprl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [CRED_W-1:0]   rsp_credits
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_credits))
    else $error("result payload changed while stalled");

  // one item in flight: no transfer in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("input ready right after a transfer");

  // a new result only appears after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result without an item in flight");

  // credits are reported only on granted requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_credits != '0 |-> rsp_status == ST_OK)
    else $error("credits reported on a refused item");

endmodule

bind per_user_problem_rate_limiter_top puprl_sva u_puprl_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_i.valid),
  .req_ready   (req_i.ready),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .rsp_status  (rsp_o.status),
  .rsp_credits (rsp_o.credits_before)
);

// ===== bench/puprl_checker.sv =====
// Checker for the rate limiter: watches the channels, predicts each result and compares
`timescale 1ns / 1ps
module puprl_checker import puprl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  puprl_req_if        req_i,
  puprl_rsp_if        rsp_i,
  puprl_cfg_if        cfg_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e           status;
    logic [CRED_W-1:0] credits_before;
  } verdict_t;

  // predicted user table
  logic              user_valid   [USER_SLOTS_DEF];
  logic [SESS_W-1:0] user_sess    [USER_SLOTS_DEF];
  logic [PROB_W-1:0] user_probs   [USER_SLOTS_DEF];
  logic [CRED_W-1:0] user_credits [USER_SLOTS_DEF];
  logic [TIME_W-1:0] user_grant   [USER_SLOTS_DEF];

  // predicted register values
  logic [SESS_W-1:0]  sess_limit;
  logic [PLIM_W-1:0]  prob_limit;
  logic [SHIFT_W-1:0] refill_sh;
  logic [CRED_W-1:0]  batch_cap;

  verdict_t    verdict_q [$];
  verdict_t    want;
  int unsigned fail_cnt;

  function automatic void fresh_user(input logic [SLOT_W-1:0] slot);
    user_valid[slot]   = 1'b1;
    user_sess[slot]    = '0;
    user_probs[slot]   = '0;
    user_credits[slot] = '0;
    user_grant[slot]   = '0;
  endfunction

  // one item: new verdict, table updated in place
  function automatic verdict_t decide_item(input logic [KIND_W-1:0] kind,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [TIME_W-1:0] stamp);
    verdict_t    v;
    logic [63:0] gain;
    logic [63:0] level;
    logic [CRED_W-1:0] held;
    v.status         = ST_OK;
    v.credits_before = '0;
    case (kind_e'(kind))
      KIND_OPEN: begin
        // unknown user opens its first session with no limit check
        if (!user_valid[slot]) begin
          fresh_user(slot);
          user_sess[slot] = 4'd1;
        end else if (user_sess[slot] >= sess_limit) begin
          v.status = ST_SESSION_LIMIT;
        end else if (user_sess[slot] == '1) begin
          v.status = ST_SATURATED;
        end else begin
          user_sess[slot] = user_sess[slot] + 1'b1;
        end
      end
      KIND_CLOSE: begin
        if (!user_valid[slot]) begin
          v.status = ST_UNKNOWN;
        end else if (user_sess[slot] == '0) begin
          v.status = ST_NO_SESSION;
        end else begin
          user_sess[slot] = user_sess[slot] - 1'b1;
        end
      end
      KIND_STORE: begin
        if (!user_valid[slot]) fresh_user(slot);
        if (user_probs[slot] == '1) v.status = ST_SATURATED;
        else user_probs[slot] = user_probs[slot] + 1'b1;
      end
      default: begin
        // root passes without touching its record
        if (slot == '0) begin
          v.credits_before = 8'd1;
        end else if (!user_valid[slot]) begin
          v.status = ST_UNKNOWN;
        end else if (prob_limit != '0 && user_probs[slot] >= {16'd0, prob_limit}) begin
          v.status = ST_PROBLEM_LIMIT;
        end else if (stamp < user_grant[slot]) begin
          v.status = ST_TIME_BACK;
        end else begin
          // refill from elapsed time, capped at the batch size
          gain  = 64'(stamp - user_grant[slot]) >> refill_sh;
          level = 64'(user_credits[slot]) + gain;
          if (gain > 64'(batch_cap) || level > 64'(batch_cap)) held = batch_cap;
          else held = level[CRED_W-1:0];
          user_credits[slot] = held;
          if (held == '0) begin
            v.status = ST_THROTTLED;
          end else begin
            user_grant[slot]   = stamp;
            v.credits_before   = held;
            user_credits[slot] = held - 1'b1;
          end
        end
      end
    endcase
    return v;
  endfunction

  // predict on request transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < USER_SLOTS_DEF; i++) begin
        user_valid[i]   = 1'b0;
        user_sess[i]    = '0;
        user_probs[i]   = '0;
        user_credits[i] = '0;
        user_grant[i]   = '0;
      end
      sess_limit = SESSION_LIMIT_RST;
      prob_limit = PROBLEM_LIMIT_RST;
      refill_sh  = REFILL_SHIFT_RST;
      batch_cap  = BATCH_SIZE_RST;
      verdict_q.delete();
      fail_cnt   = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // register write transfer
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_SESSION_LIMIT: sess_limit = cfg_i.data[SESS_W-1:0];
          CFG_PROBLEM_LIMIT: prob_limit = cfg_i.data[PLIM_W-1:0];
          CFG_REFILL_SHIFT:  refill_sh  = cfg_i.data[SHIFT_W-1:0];
          default:           batch_cap  = cfg_i.data[CRED_W-1:0];
        endcase
      end
      // result transfer against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          $display("%0t chk: result with nothing expected, status %0d credits %0d",
                   $time, rsp_i.status, rsp_i.credits_before);
        end else begin
          want = verdict_q.pop_front();
          if (rsp_i.status !== want.status) begin
            fail_cnt++;
            $display("%0t chk: status expected %0d actual %0d",
                     $time, want.status, rsp_i.status);
          end
          if (rsp_i.credits_before !== want.credits_before) begin
            fail_cnt++;
            $display("%0t chk: credits_before expected %0d actual %0d",
                     $time, want.credits_before, rsp_i.credits_before);
          end
        end
      end
      // request transfer
      if (req_i.valid && req_i.ready) begin
        verdict_q.push_back(decide_item(req_i.kind, req_i.user_slot, req_i.now_seconds));
      end
      err_cnt_o <= fail_cnt;
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the rate limiter: reset, stimulus, idle patterns and verdict
`timescale 1ns / 1ps
module tb;
  import puprl_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned MAX_GAP         = 20;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_cnt  = 0;
  int unsigned item_cnt   = 0;
  int unsigned write_cnt  = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  logic [31:0] wall_clock = '0;
  int unsigned fail_cnt;
  int unsigned pending;

  puprl_req_if req_if ();
  puprl_rsp_if rsp_if ();
  puprl_cfg_if cfg_if ();

  per_user_problem_rate_limiter_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  puprl_checker u_chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (fail_cnt),
    .pending_o (pending)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int unsigned stall_run;
    logic        stall;
    stall_run    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      stall     = ($urandom_range(0, 99) < stall_pct) && (stall_run < MAX_GAP);
      stall_run = stall ? stall_run + 1 : 0;
      rsp_if.ready <= !stall;
    end
  end

  // one request transfer, after a random gap
  task automatic send_item(input kind_e kind, input logic [5:0] slot, input logic [31:0] stamp);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.user_slot   <= slot;
    req_if.now_seconds <= stamp;
    do @(posedge clk); while (!req_if.ready);
    item_cnt++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [15:0] reg_val [4];
    kind_e       kind;
    logic [5:0]  slot;
    logic [31:0] stamp;
    int unsigned pick;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = KIND_OPEN;
    req_if.user_slot   = '0;
    req_if.now_seconds = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_SESSION_LIMIT;
    cfg_if.data        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at reset settings
    send_item(KIND_REQUEST, 6'd0, 32'd0);            // root always passes
    send_item(KIND_REQUEST, 6'd5, 32'd0);            // request from unknown user
    send_item(KIND_CLOSE, 6'd5, 32'd0);              // close on unknown user
    send_item(KIND_OPEN, 6'd5, 32'hFFFF_FFFF);       // open creates the record
    send_item(KIND_CLOSE, 6'd5, 32'd0);
    send_item(KIND_CLOSE, 6'd5, 32'd0);              // close with no session open
    repeat (6) send_item(KIND_OPEN, 6'd5, 32'd0);    // last one at the session limit
    send_item(KIND_STORE, 6'd63, 32'd0);             // store creates a fresh record
    send_item(KIND_REQUEST, 6'd63, 32'd0);           // no credits yet
    send_item(KIND_REQUEST, 6'd63, 32'hFFFF_FFFF);   // refill far past the batch
    send_item(KIND_REQUEST, 6'd63, 32'd100);         // time ran backwards
    send_item(KIND_REQUEST, 6'd63, 32'hFFFF_FFFF);   // no elapsed time, spend a held credit
    send_item(KIND_REQUEST, 6'd5, 32'd160);          // refill exactly to the batch
    send_item(KIND_REQUEST, 6'd0, 32'hFFFF_FFFF);
    send_item(KIND_STORE, 6'd0, 32'h5555_5555);
    send_item(KIND_OPEN, 6'd42, 32'hAAAA_AAAA);
    send_item(KIND_CLOSE, 6'd42, 32'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      // register settings: extremes first, then small values, the reset values, then random
      case (phase)
        0: reg_val = '{16'd15, 16'd0, 16'd0, 16'd255};
        1: reg_val = '{16'd0, 16'hFFFF, 16'd31, 16'd0};
        2: reg_val = '{16'd2, 16'd3, 16'd2, 16'd3};
        3: reg_val = '{16'd5, 16'd1000, 16'd4, 16'd10};
        default: begin
          reg_val[0] = 16'($urandom());
          reg_val[1] = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom());
          reg_val[2] = {11'($urandom()), 5'($urandom_range(0, 9))};
          reg_val[3] = 16'($urandom());
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        cfg_if.valid <= 1'b1;
        cfg_if.index <= cfg_idx_e'(i);
        cfg_if.data  <= reg_val[i];
        do @(posedge clk); while (!cfg_if.ready);
        write_cnt++;
      end
      cfg_if.valid <= 1'b0;

      // idle pattern of this phase
      case (phase % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase

      // random traffic, mostly on busy users 0 to 7 with a mostly forward clock
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      kind = KIND_OPEN;
        else if (pick < 35) kind = KIND_CLOSE;
        else if (pick < 55) kind = KIND_STORE;
        else                kind = KIND_REQUEST;
        slot  = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 7))
                                             : 6'($urandom_range(0, 63));
        stamp = $urandom();
        if (kind == KIND_REQUEST) begin
          pick = $urandom_range(0, 99);
          if (pick < 82) begin
            wall_clock += $urandom_range(0, 48);
            stamp = wall_clock;
          end else if (pick < 92) begin
            stamp = wall_clock - $urandom_range(1, 200);
          end else begin
            wall_clock = $urandom();
            stamp      = wall_clock;
          end
        end
        send_item(kind, slot, stamp);
        if ($urandom_range(0, 99) < 2) drain_results();
      end
    end

    // wind down and report
    drain_results();
    repeat (8) @(posedge clk);
    $display("tb: %0d items and %0d register writes over %0d register settings",
             item_cnt, write_cnt, RANDOM_PHASES + 1);
    $display("tb: phases mixed sender gaps, result stalls and full drains");
    if (fail_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/puprl_pkg.sv
rtl/core/puprl_if.sv
rtl/core/puprl_ram.sv
rtl/core/puprl_dp.sv
rtl/core/puprl_ctrl.sv
rtl/core/per_user_problem_rate_limiter_top.sv
rtl/core/puprl_sva.sv
bench/puprl_checker.sv
bench/tb.sv
